### rtl/amix_pkg.sv
package amix_pkg;

	localparam int MIX_DEPTH = 8192;
	localparam int MIX_AW    = $clog2(MIX_DEPTH);
	localparam int MIX_W     = 64;

	localparam logic [1:0] REG_MASTER_VOLUME = 2'd0;
	localparam logic [1:0] REG_OUTPUT_8BIT   = 2'd1;
	localparam logic [1:0] REG_OUTPUT_STEREO = 2'd2;
	localparam logic [1:0] REG_RING_LOG2     = 2'd3;

	localparam logic FUNC_ACCUMULATE = 1'b0;
	localparam logic FUNC_DRAIN      = 1'b1;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_MUL_L,
		ST_MUL_R,
		ST_FIN
	} state_t;

endpackage

### rtl/audio_mix_accumulate_and_output.sv
// Stereo mixing accumulator. An accumulate transaction (tuser[0] = 0) adds one voice
// sample, scaled by its left and right gains, into the store entry named by frame_index
// and gives no result. A drain transaction (tuser[0] = 1) reads that entry, clears it,
// scales both halves by master_volume, shifts right by 8, clamps to 16 bits and sends one
// result with the ring position of its first sample. Each transaction passes through
// ST_IDLE (store read), ST_MUL_L and ST_MUL_R (the single shared multiplier is used for
// the left half, then the right half) and ST_FIN (the entry is written back). After reset
// the block clears all 8192 store entries, one entry per cycle, before it takes its first
// transaction; configuration writes are taken during that time. A finished result waits
// in an output register while the next transaction is taken.
module audio_mix_accumulate_and_output (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// frame_index[12:0], sample_value[28:13], left_gain[36:29], right_gain[44:37], zero
	input  logic [47:0] s_tdata,
	// func[0], sample_is_narrow[1]
	input  logic [1:0]  s_tuser,
	output logic        m_tvalid,
	input  logic        m_tready,
	// first_sample[15:0], second_sample[31:16], sample_count[33:32], ring_index[49:34], zero
	output logic [55:0] m_tdata,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	amix_pkg::state_t state_q, state_nxt;

	logic [8:0]  master_volume_q;
	logic        out8_q;
	logic        stereo_q;
	logic [4:0]  ring_log2_q;

	logic [amix_pkg::MIX_AW-1:0] clr_q;
	logic [15:0]                 wpos_q;

	logic                        func_q;
	logic                        narrow_q;
	logic signed [15:0]          sample_q;
	logic [7:0]                  lg_q;
	logic [7:0]                  rg_q;
	logic [amix_pkg::MIX_AW-1:0] idx_q;
	logic signed [41:0]          prod_q;
	logic [31:0]                 left_q;

	logic        out_valid_q;
	logic [15:0] first_q;
	logic [15:0] second_q;
	logic [1:0]  count_q;
	logic [15:0] ring_q;

	logic                        accept;
	logic                        cfg_we;
	logic                        out_free;
	logic                        out_load;
	logic                        prod_en;
	logic                        left_en;
	logic                        ram_we;
	logic [amix_pkg::MIX_AW-1:0] ram_waddr;
	logic [amix_pkg::MIX_W-1:0]  ram_wdata;
	logic [amix_pkg::MIX_W-1:0]  ram_rdata;

	logic signed [31:0] mul_a;
	logic [8:0]         mul_b;
	logic signed [41:0] mul_p;
	logic signed [33:0] sh;
	logic [31:0]        scaled;
	logic [31:0]        old_half;
	logic [31:0]        sum;
	logic [15:0]        c16;
	logic [15:0]        d16;
	logic [31:0]        post_val;
	logic [4:0]         lg2;
	logic [16:0]        mask17;
	logic [15:0]        pos_x;

	assign accept   = s_tvalid && s_tready;
	assign cfg_we   = psel && penable && pwrite && pready;
	assign out_free = !out_valid_q || m_tready;
	assign pready   = 1'b1;

	always_comb begin
		unique case (paddr[3:2])
			amix_pkg::REG_MASTER_VOLUME: prdata = {23'd0, master_volume_q};
			amix_pkg::REG_OUTPUT_8BIT:   prdata = {31'd0, out8_q};
			amix_pkg::REG_OUTPUT_STEREO: prdata = {31'd0, stereo_q};
			amix_pkg::REG_RING_LOG2:     prdata = {27'd0, ring_log2_q};
			default:                     prdata = 32'd0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			master_volume_q <= 9'd179;
			out8_q          <= 1'b0;
			stereo_q        <= 1'b1;
			ring_log2_q     <= 5'd14;
		end else if (cfg_we) begin
			unique case (paddr[3:2])
				amix_pkg::REG_MASTER_VOLUME: master_volume_q <= pwdata[8:0];
				amix_pkg::REG_OUTPUT_8BIT:   out8_q          <= pwdata[0];
				amix_pkg::REG_OUTPUT_STEREO: stereo_q        <= pwdata[0];
				amix_pkg::REG_RING_LOG2:     ring_log2_q     <= pwdata[4:0];
				default: ;
			endcase
		end
	end

	// next state
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			amix_pkg::ST_CLEAR: begin
				if (clr_q == amix_pkg::MIX_AW'(amix_pkg::MIX_DEPTH - 1)) begin
					state_nxt = amix_pkg::ST_IDLE;
				end
			end
			amix_pkg::ST_IDLE: begin
				if (s_tvalid) begin
					state_nxt = amix_pkg::ST_MUL_L;
				end
			end
			amix_pkg::ST_MUL_L: state_nxt = amix_pkg::ST_MUL_R;
			amix_pkg::ST_MUL_R: state_nxt = amix_pkg::ST_FIN;
			amix_pkg::ST_FIN: begin
				if (func_q == amix_pkg::FUNC_ACCUMULATE || out_free) begin
					state_nxt = amix_pkg::ST_IDLE;
				end
			end
			default: state_nxt = amix_pkg::ST_CLEAR;
		endcase
	end

	// sequencer outputs
	always_comb begin
		s_tready  = 1'b0;
		prod_en   = 1'b0;
		left_en   = 1'b0;
		out_load  = 1'b0;
		ram_we    = 1'b0;
		ram_waddr = idx_q;
		ram_wdata = '0;
		unique case (state_q)
			amix_pkg::ST_CLEAR: begin
				ram_we    = 1'b1;
				ram_waddr = clr_q;
			end
			amix_pkg::ST_IDLE: s_tready = 1'b1;
			amix_pkg::ST_MUL_L: prod_en = 1'b1;
			amix_pkg::ST_MUL_R: begin
				prod_en = 1'b1;
				left_en = 1'b1;
			end
			amix_pkg::ST_FIN: begin
				ram_we = 1'b1;
				if (func_q == amix_pkg::FUNC_ACCUMULATE) begin
					ram_wdata = {post_val, left_q};
				end
				out_load = (func_q == amix_pkg::FUNC_DRAIN) && out_free;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= amix_pkg::ST_CLEAR;
			clr_q       <= '0;
			wpos_q      <= 16'd0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (state_q == amix_pkg::ST_CLEAR) begin
				clr_q <= clr_q + 1'b1;
			end
			if (out_load) begin
				wpos_q      <= wpos_q + 16'd1;
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	amix_ram #(
		.WIDTH(amix_pkg::MIX_W),
		.DEPTH(amix_pkg::MIX_DEPTH)
	) u_store (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (accept),
		.raddr(amix_pkg::MIX_AW'(s_tdata[12:0])),
		.rdata(ram_rdata)
	);

	// shared multiplier: voice sample times gain, or stored sum times master volume
	always_comb begin
		if (func_q == amix_pkg::FUNC_DRAIN) begin
			mul_a = (state_q == amix_pkg::ST_MUL_R) ? ram_rdata[63:32] : ram_rdata[31:0];
			mul_b = master_volume_q;
		end else begin
			mul_a = narrow_q ? 32'(signed'(sample_q[7:0])) : 32'(sample_q);
			mul_b = {1'b0, (state_q == amix_pkg::ST_MUL_R) ? rg_q : lg_q};
		end
		mul_p = mul_a * $signed({1'b0, mul_b});
	end

	// post-processing of the product in prod_q
	always_comb begin
		sh       = prod_q[41:8];
		scaled   = narrow_q ? prod_q[31:0] : prod_q[39:8];
		old_half = (state_q == amix_pkg::ST_MUL_R) ? ram_rdata[31:0] : ram_rdata[63:32];
		sum      = old_half + scaled;
		if (sh > 34'sd32767) begin
			c16 = 16'h7fff;
		end else if (sh < -34'sd32768) begin
			c16 = 16'h8000;
		end else begin
			c16 = sh[15:0];
		end
		d16      = out8_q ? {8'h00, ~c16[15], c16[14:8]} : c16;
		post_val = (func_q == amix_pkg::FUNC_DRAIN) ? {16'h0000, d16} : sum;
	end

	always_comb begin
		lg2    = (ring_log2_q > 5'd16) ? 5'd16 : ring_log2_q;
		mask17 = (17'd1 << lg2) - 17'd1;
		pos_x  = stereo_q ? {wpos_q[14:0], 1'b0} : wpos_q;
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			func_q   <= s_tuser[0];
			narrow_q <= s_tuser[1];
			idx_q    <= amix_pkg::MIX_AW'(s_tdata[12:0]);
			sample_q <= s_tdata[28:13];
			lg_q     <= s_tdata[36:29];
			rg_q     <= s_tdata[44:37];
		end
		if (prod_en) begin
			prod_q <= mul_p;
		end
		if (left_en) begin
			left_q <= post_val;
		end
		if (out_load) begin
			first_q  <= left_q[15:0];
			second_q <= stereo_q ? post_val[15:0] : 16'd0;
			count_q  <= stereo_q ? 2'd2 : 2'd1;
			ring_q   <= pos_x & mask17[15:0];
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {6'd0, ring_q, count_q, second_q, first_q};

`ifndef SYNTHESIS
	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> state_q == amix_pkg::ST_MUL_L)
		else $error("transaction accepted but sequencer did not start");

	a_result_from_drain: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(state_q == amix_pkg::ST_FIN && func_q == amix_pkg::FUNC_DRAIN))
		else $error("result appeared without a drain");

	a_wpos_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!out_load |=> $stable(wpos_q))
		else $error("write position moved without a result");

	a_no_accept_clear: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == amix_pkg::ST_CLEAR |-> !s_tready && ram_we)
		else $error("store clearing pass disturbed");
`endif

endmodule

### rtl/amix_ram.sv
module amix_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 8192
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule
